@@ src/lres_pkg.sv @@
package lres_pkg;

  localparam int CELL_W  = 10;
  localparam int GENE_W  = 8;
  localparam int PAIR_W  = 6;
  localparam int SLOT_W  = 2;
  localparam int CNT_W   = 3;
  localparam int NSUB    = 4;
  localparam int EXPR_W  = 16;
  localparam int SCORE_W = 32;
  localparam int ROOT_W  = 16;
  localparam int LIST_W  = PAIR_W + 1;
  localparam int COL_AW  = LIST_W + SLOT_W;
  localparam int EXPR_AW = CELL_W + GENE_W;

  localparam logic [1:0] CMD_LOAD_EXPR = 2'd0;
  localparam logic [1:0] CMD_LOAD_COL  = 2'd1;
  localparam logic [1:0] CMD_SCORE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SQRT,
    ST_SCALE,
    ST_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic                  take;
    logic                  rd_issue;
    logic                  rd_side;
    logic [SLOT_W-1:0]     rd_slot;
    logic                  rd_first;
    logic                  mul;
    logic                  sqrt_init;
    logic                  sqrt_step;
    logic                  scale;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic             is_score;
    logic [CNT_W-1:0] lig_cnt;
    logic [CNT_W-1:0] rec_cnt;
  } stat_t;

endpackage

@@ src/lres_datapath.sv @@
module lres_datapath (
  input  logic                                  clk_i,
  input  lres_pkg::ctrl_t                       ctrl_i,
  output lres_pkg::stat_t                       stat_o,
  input  logic [1:0]                            cmd_i,
  input  logic [lres_pkg::CELL_W-1:0]           cell_req_i,
  input  logic [lres_pkg::CELL_W-1:0]           receiver_cell_i,
  input  logic [lres_pkg::GENE_W-1:0]           gene_i,
  input  logic signed [lres_pkg::EXPR_W-1:0]    expr_value_i,
  input  logic [lres_pkg::PAIR_W-1:0]           pair_i,
  input  logic                                  side_i,
  input  logic [lres_pkg::SLOT_W-1:0]           slot_i,
  input  logic [lres_pkg::CNT_W-1:0]            subunit_count_i,
  input  logic signed [15:0]                    weight_i,
  input  logic                                  rst_ni,
  output logic signed [lres_pkg::SCORE_W-1:0]   score_o
);

  logic signed [lres_pkg::EXPR_W-1:0] expr_mem [2**lres_pkg::EXPR_AW];
  logic [lres_pkg::GENE_W-1:0]        col_mem  [2**lres_pkg::COL_AW];
  logic [lres_pkg::CNT_W-1:0]         cnt_mem  [2**lres_pkg::LIST_W];
  logic [2**lres_pkg::LIST_W-1:0]     cnt_vld_q;

  logic [lres_pkg::CNT_W-1:0] lig_raw_q, rec_raw_q;
  logic                       lig_vld_q, rec_vld_q;

  logic [lres_pkg::CELL_W-1:0] snd_q, rcv_q;
  logic [lres_pkg::PAIR_W-1:0] pair_q;
  logic signed [15:0]          w_q;

  logic [lres_pkg::GENE_W-1:0] col_rd_q;
  logic                        cside_q, cvalid_q, cfirst_q;
  logic                        eside_q, evalid_q, efirst_q;
  logic signed [lres_pkg::EXPR_W-1:0] expr_rd_q;
  logic signed [lres_pkg::EXPR_W-1:0] lmin_q, rmin_q;
  logic [31:0] x_q, res_q, bit_q;
  logic signed [lres_pkg::SCORE_W-1:0] score_q;
  logic [lres_pkg::CNT_W-1:0] cnt_sat;
  logic [31:0] trial;

  assign cnt_sat = (subunit_count_i > lres_pkg::CNT_W'(lres_pkg::NSUB)) ?
                   lres_pkg::CNT_W'(lres_pkg::NSUB) : subunit_count_i;

  assign stat_o.is_score = (cmd_i == lres_pkg::CMD_SCORE);
  assign stat_o.lig_cnt  = lig_vld_q ? lig_raw_q : '0;
  assign stat_o.rec_cnt  = rec_vld_q ? rec_raw_q : '0;

  // A list that was never loaded counts as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (ctrl_i.take && cmd_i == lres_pkg::CMD_LOAD_COL) begin
      cnt_vld_q[{pair_i, side_i}] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && cmd_i == lres_pkg::CMD_LOAD_EXPR) begin
      expr_mem[{cell_req_i, gene_i}] <= expr_value_i;
    end
    if (ctrl_i.take && cmd_i == lres_pkg::CMD_LOAD_COL) begin
      col_mem[{pair_i, side_i, slot_i}] <= gene_i;
      cnt_mem[{pair_i, side_i}]         <= cnt_sat;
    end
    if (ctrl_i.take) begin
      snd_q     <= cell_req_i;
      rcv_q     <= receiver_cell_i;
      pair_q    <= pair_i;
      w_q       <= weight_i;
      lig_raw_q <= cnt_mem[{pair_i, 1'b0}];
      rec_raw_q <= cnt_mem[{pair_i, 1'b1}];
      lig_vld_q <= cnt_vld_q[{pair_i, 1'b0}];
      rec_vld_q <= cnt_vld_q[{pair_i, 1'b1}];
    end
  end

  // Two-stage read: column table, then expression store, then running minimum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= 1'b0;
      evalid_q <= 1'b0;
    end else begin
      cvalid_q <= ctrl_i.rd_issue;
      evalid_q <= cvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col_rd_q  <= col_mem[{pair_q, ctrl_i.rd_side, ctrl_i.rd_slot}];
    cside_q   <= ctrl_i.rd_side;
    cfirst_q  <= ctrl_i.rd_first;
    expr_rd_q <= expr_mem[{cside_q ? rcv_q : snd_q, col_rd_q}];
    eside_q   <= cside_q;
    efirst_q  <= cfirst_q;
    if (ctrl_i.take) begin
      lmin_q <= '0;
      rmin_q <= '0;
    end else if (evalid_q) begin
      if (!eside_q) begin
        if (efirst_q || expr_rd_q < lmin_q) lmin_q <= expr_rd_q;
      end else begin
        if (efirst_q || expr_rd_q < rmin_q) rmin_q <= expr_rd_q;
      end
    end
  end

  assign trial = res_q + bit_q;

  // Product, then digit-by-digit square root, one result bit per cycle, then scale.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      x_q <= (lmin_q[15] ? 32'd0 : {17'd0, lmin_q[14:0]}) *
             (rmin_q[15] ? 32'd0 : {17'd0, rmin_q[14:0]});
    end
    if (ctrl_i.sqrt_init) begin
      res_q <= '0;
      bit_q <= 32'h4000_0000;
    end else if (ctrl_i.sqrt_step) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (ctrl_i.scale) begin
      score_q <= $signed({1'b0, res_q[lres_pkg::ROOT_W-1:0]}) * w_q;
    end
  end

  assign score_o = score_q;

endmodule

@@ src/lres_ctrl.sv @@
module lres_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lres_pkg::stat_t stat_i,
  output lres_pkg::ctrl_t ctrl_o
);

  lres_pkg::state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [3:0] tot;
  logic [3:0] nlim;

  assign tot  = {1'b0, stat_i.lig_cnt} + {1'b0, stat_i.rec_cnt};
  assign nlim = tot + 4'd2;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      lres_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid && stat_i.is_score) state_d = lres_pkg::ST_READ;
      end
      lres_pkg::ST_READ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == nlim) begin
          state_d = lres_pkg::ST_MUL;
          cnt_d   = '0;
        end
      end
      lres_pkg::ST_MUL: state_d = lres_pkg::ST_SQRT;
      lres_pkg::ST_SQRT: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = lres_pkg::ST_SCALE;
      end
      lres_pkg::ST_SCALE: state_d = lres_pkg::ST_OUT;
      lres_pkg::ST_OUT:   if (out_ready) state_d = lres_pkg::ST_IDLE;
      default:            state_d = lres_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o    = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_q)
      lres_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctrl_o.take = in_valid;
      end
      lres_pkg::ST_READ: begin
        // Ligand subunits first, then receptor subunits.
        if (cnt_q < tot) begin
          ctrl_o.rd_issue = 1'b1;
          if (cnt_q < {1'b0, stat_i.lig_cnt}) begin
            ctrl_o.rd_side  = 1'b0;
            ctrl_o.rd_slot  = cnt_q[1:0];
            ctrl_o.rd_first = (cnt_q == 4'd0);
          end else begin
            ctrl_o.rd_side  = 1'b1;
            ctrl_o.rd_slot  = 2'(cnt_q - {1'b0, stat_i.lig_cnt});
            ctrl_o.rd_first = (cnt_q == {1'b0, stat_i.lig_cnt});
          end
        end
      end
      lres_pkg::ST_MUL: begin
        ctrl_o.mul       = 1'b1;
        ctrl_o.sqrt_init = 1'b1;
      end
      lres_pkg::ST_SQRT:  ctrl_o.sqrt_step = 1'b1;
      lres_pkg::ST_SCALE: ctrl_o.scale     = 1'b1;
      lres_pkg::ST_OUT:   out_valid        = 1'b1;
      default: ;
    endcase
  end

  logic scale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lres_pkg::ST_IDLE;
      cnt_q   <= '0;
      scale_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scale_q <= (state_q == lres_pkg::ST_SCALE);
    end
  end

  a_out_after_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> scale_q) else $error("result without scaling");
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_sqrt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lres_pkg::ST_SCALE) |-> $past(state_q) == lres_pkg::ST_SQRT)
    else $error("scale without root");

endmodule

@@ src/ligand_receptor_edge_score_core.sv @@
// Load requests are accepted one per cycle while no score request is in work, and give no result.
// A score request offers its result after the subunit reads, the read pipeline, a multiply,
// 16 square root steps and a scale.
// One request is in work at a time, so a new request waits until the score result is taken.
// Reset (rst_ni low, asynchronous) clears the controller and the subunit counts;
// the expression store and the column table hold their contents.
module ligand_receptor_edge_score_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         cell_req_i,
  input  logic [9:0]         receiver_cell_i,
  input  logic [7:0]         gene_i,
  input  logic signed [15:0] expr_value_i,
  input  logic [5:0]         pair_i,
  input  logic               side_i,
  input  logic [1:0]         slot_i,
  input  logic [2:0]         subunit_count_i,
  input  logic signed [15:0] weight_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] score_o
);

  lres_pkg::ctrl_t ctrl;
  lres_pkg::stat_t stat;

  lres_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  lres_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i, .cell_req_i, .receiver_cell_i, .gene_i, .expr_value_i, .pair_i,
    .side_i, .slot_i, .subunit_count_i, .weight_i, .score_o
  );

endmodule

@@ tb/tb_ligand_receptor_edge_score_core.sv @@
module tb_ligand_receptor_edge_score_core;

  typedef struct {
    logic [1:0]         cmd;
    logic [9:0]         cell_row;
    logic [9:0]         rcell;
    logic [7:0]         gene;
    logic signed [15:0] ev;
    logic [5:0]         pair;
    logic               side;
    logic [1:0]         slot;
    logic [2:0]         cnt;
    logic signed [15:0] w;
    bit                 drain;
  } req_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_REQS = 1400;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         cmd_i = '0;
  logic [9:0]         cell_req_i = '0;
  logic [9:0]         receiver_cell_i = '0;
  logic [7:0]         gene_i = '0;
  logic signed [15:0] expr_value_i = '0;
  logic [5:0]         pair_i = '0;
  logic               side_i = 1'b0;
  logic [1:0]         slot_i = '0;
  logic [2:0]         subunit_count_i = '0;
  logic signed [15:0] weight_i = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] score_o;

  ligand_receptor_edge_score_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow of the tables as the requests are generated, used only to keep
  // score requests away from entries that were never written.
  bit         gen_expr_written [262144];
  bit         gen_col_written [512];
  logic [7:0] gen_col [512];
  logic [2:0] gen_cnt [128];

  // Predictor state, updated at acceptance.
  logic signed [15:0] expr_mem [262144];
  logic [7:0]         col_mem [512];
  logic [2:0]         cnt_mem [128];

  req_t               pending_reqs [$];
  logic signed [31:0] expected_scores [$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 results_seen = 0;

  function automatic logic [2:0] sat_count(logic [2:0] c);
    return (c > lres_pkg::NSUB) ? 3'(lres_pkg::NSUB) : c;
  endfunction

  function automatic void push_req(req_t r);
    logic [6:0] lst;
    lst = {r.pair, r.side};
    if (r.cmd == lres_pkg::CMD_LOAD_EXPR) begin
      gen_expr_written[{r.cell_row, r.gene}] = 1'b1;
    end else if (r.cmd == lres_pkg::CMD_LOAD_COL) begin
      gen_col_written[{lst, r.slot}] = 1'b1;
      gen_col[{lst, r.slot}] = r.gene;
      gen_cnt[lst] = sat_count(r.cnt);
    end
    pending_reqs.push_back(r);
  endfunction

  function automatic logic signed [15:0] rand_expr();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [9:0] rand_cell();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      2, 3: return 10'($urandom);
      default: return 10'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic req_t blank_req();
    req_t r;
    r.cmd = CMD_UNUSED;
    r.cell_row = 10'($urandom);
    r.rcell = 10'($urandom);
    r.gene = 8'($urandom);
    r.ev = 16'($urandom);
    r.pair = 6'($urandom);
    r.side = 1'($urandom);
    r.slot = 2'($urandom);
    r.cnt = 3'($urandom);
    r.w = 16'($urandom);
    r.drain = 0;
    return r;
  endfunction

  function automatic void push_expr(logic [9:0] c, logic [7:0] g, logic signed [15:0] v);
    req_t r;
    r = blank_req();
    r.cmd = lres_pkg::CMD_LOAD_EXPR;
    r.cell_row = c;
    r.gene = g;
    r.ev = v;
    push_req(r);
  endfunction

  function automatic void push_col(logic [5:0] p, logic s, logic [1:0] sl, logic [7:0] g,
                                   logic [2:0] c);
    req_t r;
    r = blank_req();
    r.cmd = lres_pkg::CMD_LOAD_COL;
    r.pair = p;
    r.side = s;
    r.slot = sl;
    r.gene = g;
    r.cnt = c;
    push_req(r);
  endfunction

  // Loads whatever the score request would read and was never written, then
  // queues the score request itself.
  function automatic void push_score(logic [9:0] snd, logic [9:0] rcv, logic [5:0] p,
                                     logic signed [15:0] w, bit drain);
    req_t r;
    logic [6:0] lst;
    logic [9:0] c;
    for (int s = 0; s < 2; s++) begin
      lst = {p, 1'(s)};
      c = s ? rcv : snd;
      for (int k = 0; k < gen_cnt[lst]; k++) begin
        if (!gen_col_written[{lst, 2'(k)}])
          push_col(p, 1'(s), 2'(k), 8'($urandom_range(0, 31)), gen_cnt[lst]);
        if (!gen_expr_written[{c, gen_col[{lst, 2'(k)}]}])
          push_expr(c, gen_col[{lst, 2'(k)}], rand_expr());
      end
    end
    r = blank_req();
    r.cmd = lres_pkg::CMD_SCORE;
    r.cell_row = snd;
    r.rcell = rcv;
    r.pair = p;
    r.w = w;
    r.drain = drain;
    push_req(r);
  endfunction

  function automatic logic [15:0] isqrt32(logic [31:0] x);
    logic [31:0] rem, res, bitv;
    rem = x;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[15:0];
  endfunction

  function automatic logic [15:0] clamped_min(logic [6:0] lst, logic [9:0] c);
    logic signed [15:0] m, v;
    m = 0;
    for (int k = 0; k < cnt_mem[lst]; k++) begin
      v = expr_mem[{c, col_mem[{lst, 2'(k)}]}];
      if (k == 0 || v < m) m = v;
    end
    return (m > 0) ? m : 16'd0;
  endfunction

  function automatic void apply_req(req_t r);
    logic [15:0] lig, rec, root;
    logic signed [31:0] sc;
    case (r.cmd)
      lres_pkg::CMD_LOAD_EXPR: expr_mem[{r.cell_row, r.gene}] = r.ev;
      lres_pkg::CMD_LOAD_COL: begin
        col_mem[{r.pair, r.side, r.slot}] = r.gene;
        cnt_mem[{r.pair, r.side}] = sat_count(r.cnt);
      end
      lres_pkg::CMD_SCORE: begin
        lig = clamped_min({r.pair, 1'b0}, r.cell_row);
        rec = clamped_min({r.pair, 1'b1}, r.rcell);
        root = isqrt32({16'd0, lig} * {16'd0, rec});
        sc = $signed({16'd0, root}) * $signed({{16{r.w[15]}}, r.w});
        expected_scores.push_back(sc);
      end
      default: ;
    endcase
  endfunction

  // Request driver.
  req_t cur_req;
  int   send_gap = 0;
  bit   send_busy;
  bit   send_no_idle = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      send_busy = in_valid;
      if (in_valid && in_ready) begin
        apply_req(cur_req);
        send_busy = 0;
        if ($urandom_range(0, 199) == 0) send_no_idle = ~send_no_idle;
        send_gap = send_no_idle ? 0 : $urandom_range(0, 8);
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_scores.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          cmd_i <= cur_req.cmd;
          cell_req_i <= cur_req.cell_row;
          receiver_cell_i <= cur_req.rcell;
          gene_i <= cur_req.gene;
          expr_value_i <= cur_req.ev;
          pair_i <= cur_req.pair;
          side_i <= cur_req.side;
          slot_i <= cur_req.slot;
          subunit_count_i <= cur_req.cnt;
          weight_i <= cur_req.w;
          send_busy = 1;
        end
      end
      in_valid <= send_busy;
    end
  end

  // Result monitor; the receiver stalls a long stretch once, mid-run.
  int  recv_hold = 0;
  bit  recv_no_idle = 0;
  logic signed [31:0] exp_score;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected score result %0d", score_o);
          errors++;
        end else begin
          exp_score = expected_scores.pop_front();
          if (score_o !== exp_score) begin
            $error("score mismatch: expected %0d actual %0d", exp_score, score_o);
            errors++;
          end
        end
        results_seen++;
        if ($urandom_range(0, 99) == 0) recv_no_idle = ~recv_no_idle;
        recv_hold = (results_seen == 150) ? 400 : (recv_no_idle ? 0 : $urandom_range(0, 8));
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 128; i++) begin
      gen_cnt[i] = '0;
      cnt_mem[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty lists give zero.
    push_col(6'd0, 1'b0, 2'd0, 8'd0, 3'd0);
    push_col(6'd0, 1'b1, 2'd1, 8'd1, 3'd0);
    push_score(10'd0, 10'd1023, 6'd0, 16'sd32767, 0);
    // Count above the list size saturates; top pair, top gene, top slot.
    push_col(6'd63, 1'b0, 2'd3, 8'd255, 3'd7);
    push_col(6'd63, 1'b1, 2'd0, 8'd255, 3'd1);
    push_expr(10'd1023, 8'd255, 16'sd32767);
    push_score(10'd1023, 10'd1023, 6'd63, -16'sd32768, 0);
    push_score(10'd1023, 10'd1023, 6'd63, 16'sd32767, 0);
    // A negative minimum clamps to zero.
    push_col(6'd42, 1'b0, 2'd0, 8'd170, 3'd1);
    push_col(6'd42, 1'b1, 2'd0, 8'd85, 3'd1);
    push_expr(10'd682, 8'd170, -16'sd32768);
    push_expr(10'd341, 8'd85, 16'sd32767);
    push_score(10'd682, 10'd341, 6'd42, 16'sd256, 0);
    push_expr(10'd682, 8'd170, 16'sd1);
    push_score(10'd682, 10'd341, 6'd42, -16'sd1, 0);
    // The unused command is ignored.
    begin
      req_t r;
      r = blank_req();
      push_req(r);
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          push_score(rand_cell(), rand_cell(), 6'($urandom_range(0, 7)) |
                     ($urandom_range(0, 3) == 0 ? 6'($urandom) : 6'd0),
                     16'($urandom), n == RANDOM_REQS / 2);
        9, 10, 11, 12, 13:
          push_expr(rand_cell(), 8'($urandom_range(0, 31)), rand_expr());
        14, 15, 16, 17:
          push_col(6'($urandom_range(0, 7)), 1'($urandom), 2'($urandom),
                   8'($urandom_range(0, 31)), 3'($urandom));
        default: begin
          req_t r;
          r = blank_req();
          push_req(r);
        end
      endcase
    end

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_scores.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
